// ===== hw/rtl/spmr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// spmr_pkg
// Shared types and constants of the sepia and row mirror pixel stream.
// ----------------------------------------------------------------------------
package spmr_pkg;

	localparam int PIX_W       = 8;
	localparam int ROW_WIDTH_W = 11;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 11;

	localparam logic [ROW_WIDTH_W-1:0] ROW_WIDTH_RESET = 11'd640;

	// channel positions inside a packed pixel
	localparam int CH_RED   = 2;
	localparam int CH_GREEN = 1;
	localparam int CH_BLUE  = 0;

	typedef logic [2:0][PIX_W-1:0] pixel_t;

	typedef struct packed {
		pixel_t pix;
		logic   row_end;
	} out_word_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SEPIA_ENABLE  = 2'd0,
		REG_MIRROR_ENABLE = 2'd1,
		REG_ROW_WIDTH     = 2'd2
	} cfg_reg_e;

	// per-item control decided at accept time
	typedef struct packed {
		logic emit;
		logic from_mem;
		logic row_end;
		logic wr_en;
		logic sepia;
	} ctrl_t;

	// sepia arithmetic
	localparam int COEF_W      = 10;
	localparam int PROD_W      = 18;
	localparam int SUM_W       = 19;
	localparam int RECIP_W     = 19;
	localparam int MUL_W       = SUM_W + RECIP_W;
	localparam int RECIP_SHIFT = 28;
	localparam int QUOT_W      = 9;
	// ceil(2^28 / 1000), exact floor division for sums below 493447
	localparam logic [RECIP_W-1:0] SEPIA_RECIP = 19'd268436;

	localparam int OUT_FIFO_DEPTH = 8;
	localparam int OUT_FIFO_AW    = $clog2(OUT_FIFO_DEPTH);
	localparam int OUT_FIFO_CW    = $clog2(OUT_FIFO_DEPTH + 1);

	function automatic logic [COEF_W-1:0] sepia_coef(input logic [1:0] o, input logic [1:0] i);
		logic [COEF_W-1:0] c;
		c = '0;
		case (o)
			2'(CH_RED): begin
				case (i)
					2'(CH_RED):   c = 10'd393;
					2'(CH_GREEN): c = 10'd769;
					2'(CH_BLUE):  c = 10'd189;
					default:      c = '0;
				endcase
			end
			2'(CH_GREEN): begin
				case (i)
					2'(CH_RED):   c = 10'd349;
					2'(CH_GREEN): c = 10'd686;
					2'(CH_BLUE):  c = 10'd168;
					default:      c = '0;
				endcase
			end
			2'(CH_BLUE): begin
				case (i)
					2'(CH_RED):   c = 10'd272;
					2'(CH_GREEN): c = 10'd534;
					2'(CH_BLUE):  c = 10'd131;
					default:      c = '0;
				endcase
			end
			default: c = '0;
		endcase
		return c;
	endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/spmr_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// spmr_if
// Valid/ready channels of the pixel stream: pixel in, pixel out, config write.
// ----------------------------------------------------------------------------
interface spmr_pix_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic       drain;

	modport source (output valid, output red, output green, output blue, output drain,
		input ready);
	modport sink (input valid, input red, input green, input blue, input drain,
		output ready);
endinterface

interface spmr_pix_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_red;
	logic [7:0] out_green;
	logic [7:0] out_blue;
	logic       row_end;

	modport source (output valid, output out_red, output out_green, output out_blue,
		output row_end, input ready);
	modport sink (input valid, input out_red, input out_green, input out_blue,
		input row_end, output ready);
endinterface

interface spmr_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [10:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/sepia_and_row_mirror_pixel_stream.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// sepia_and_row_mirror_pixel_stream
// Sepia tone and horizontal row mirror filter on an RGB pixel stream.
// ----------------------------------------------------------------------------
// One word is taken per clock. Each word runs through a pipeline: input
// register, three stages of sepia arithmetic (products, sums, divide by
// 1000 through a reciprocal multiply), then the row store access, whose read
// data is registered; the result then enters an eight-word output queue, and the
// queue's head feeds the output. Ready drops only while eight results
// are outstanding (in flight or queued), so the rate is one word per cycle as
// long as the output side keeps taking results. With mirroring on, output runs
// one row behind input and drain words push out the last row. The row store
// holds two rows of MAX_ROW_WIDTH pixels and needs no clearing after reset.
module sepia_and_row_mirror_pixel_stream
	import spmr_pkg::*;
#(
	parameter int MAX_ROW_WIDTH = 1024
) (
	input  logic            clk,
	input  logic            arst_n,
	spmr_pix_in_if.sink     pix_in,
	spmr_pix_out_if.source  pix_out,
	spmr_cfg_if.sink        cfg
);

	localparam int AW = $clog2(2 * MAX_ROW_WIDTH);

	logic                   sepia_en_q;
	logic                   mirror_en_q;
	logic [ROW_WIDTH_W-1:0] row_width_q;

	logic                   accept;
	logic                   pop;
	logic [OUT_FIFO_CW-1:0] cred_q;

	ctrl_t                  ctrl;
	logic [AW-1:0]          wr_addr, rd_addr;

	ctrl_t                  ctrl_s1, ctrl_s2, ctrl_s3, ctrl_s4, ctrl_s5;
	logic [AW-1:0]          wr_addr_s1, wr_addr_s2, wr_addr_s3, wr_addr_s4;
	logic [AW-1:0]          rd_addr_s1, rd_addr_s2, rd_addr_s3, rd_addr_s4;
	pixel_t                 pix_s1, pix_s4, pass_s5, rd_data_s5;
	out_word_t              push_word;

	// configuration
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sepia_en_q  <= 1'b0;
			mirror_en_q <= 1'b0;
			row_width_q <= ROW_WIDTH_RESET;
		end else if (cfg.valid) begin
			unique case (cfg_reg_e'(cfg.index))
				REG_SEPIA_ENABLE:  sepia_en_q  <= cfg.data[0];
				REG_MIRROR_ENABLE: mirror_en_q <= cfg.data[0];
				REG_ROW_WIDTH:     row_width_q <= cfg.data;
				default:           ;
			endcase
		end
	end

	// credit for results not yet taken
	assign pix_in.ready = cred_q < OUT_FIFO_CW'(OUT_FIFO_DEPTH);
	assign accept       = pix_in.valid && pix_in.ready;
	assign pop          = pix_out.valid && pix_out.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cred_q <= '0;
		end else begin
			case ({ctrl.emit, pop})
				2'b10:   cred_q <= cred_q + OUT_FIFO_CW'(1);
				2'b01:   cred_q <= cred_q - OUT_FIFO_CW'(1);
				default: cred_q <= cred_q;
			endcase
		end
	end

	spmr_ctrl #(
		.MAX_ROW_WIDTH (MAX_ROW_WIDTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.drain     (pix_in.drain),
		.sepia_en  (sepia_en_q),
		.mirror_en (mirror_en_q),
		.row_width (row_width_q),
		.ctrl      (ctrl),
		.wr_addr   (wr_addr),
		.rd_addr   (rd_addr)
	);

	// control pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
			ctrl_s2 <= '0;
			ctrl_s3 <= '0;
			ctrl_s4 <= '0;
			ctrl_s5 <= '0;
		end else begin
			ctrl_s1 <= ctrl;
			ctrl_s2 <= ctrl_s1;
			ctrl_s3 <= ctrl_s2;
			ctrl_s4 <= ctrl_s3;
			ctrl_s5 <= ctrl_s4;
		end
	end

	always_ff @(posedge clk) begin
		pix_s1[CH_RED]   <= pix_in.red;
		pix_s1[CH_GREEN] <= pix_in.green;
		pix_s1[CH_BLUE]  <= pix_in.blue;
		wr_addr_s1       <= wr_addr;
		wr_addr_s2       <= wr_addr_s1;
		wr_addr_s3       <= wr_addr_s2;
		wr_addr_s4       <= wr_addr_s3;
		rd_addr_s1       <= rd_addr;
		rd_addr_s2       <= rd_addr_s1;
		rd_addr_s3       <= rd_addr_s2;
		rd_addr_s4       <= rd_addr_s3;
		pass_s5          <= pix_s4;
	end

	spmr_sepia u_sepia (
		.clk      (clk),
		.pix_s1   (pix_s1),
		.sepia_s1 (ctrl_s1.sepia),
		.pix_s4   (pix_s4)
	);

	spmr_row_store #(
		.DEPTH (2 * MAX_ROW_WIDTH)
	) u_row_store (
		.clk     (clk),
		.wr_en   (ctrl_s4.wr_en),
		.wr_addr (wr_addr_s4),
		.wr_data (pix_s4),
		.rd_en   (ctrl_s4.from_mem),
		.rd_addr (rd_addr_s4),
		.rd_data (rd_data_s5)
	);

	assign push_word.pix     = ctrl_s5.from_mem ? rd_data_s5 : pass_s5;
	assign push_word.row_end = ctrl_s5.row_end;

	spmr_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (ctrl_s5.emit),
		.push_word (push_word),
		.pix_out   (pix_out)
	);

	// outstanding results never exceed the queue
	assert property (@(posedge clk) disable iff (!arst_n)
		cred_q <= OUT_FIFO_CW'(OUT_FIFO_DEPTH))
	else $error("result credit overflow");

endmodule
`default_nettype wire

// ===== hw/rtl/spmr_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// spmr_ctrl
// Row bookkeeping: write and read columns, bank select, pending row.
// ----------------------------------------------------------------------------
module spmr_ctrl
	import spmr_pkg::*;
#(
	parameter int MAX_ROW_WIDTH = 1024,
	localparam int EFF_MAX = (MAX_ROW_WIDTH < 2047) ? MAX_ROW_WIDTH : 2047,
	localparam int CW      = $clog2(EFF_MAX),
	localparam int WW      = $clog2(EFF_MAX + 1),
	localparam int AW      = $clog2(2 * MAX_ROW_WIDTH)
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   accept,
	input  logic                   drain,
	input  logic                   sepia_en,
	input  logic                   mirror_en,
	input  logic [ROW_WIDTH_W-1:0] row_width,
	output ctrl_t                  ctrl,
	output logic [AW-1:0]          wr_addr,
	output logic [AW-1:0]          rd_addr
);

	logic [CW-1:0] wc_q, wc_d;
	logic [CW-1:0] rc_q, rc_d;
	logic          wb_q, wb_d;
	logic          pend_q, pend_d;

	logic [WW-1:0] w;
	logic          last;
	logic          rd_end;
	logic [CW-1:0] rd_col;
	logic          from_mem;

	always_comb begin
		if (row_width == '0) begin
			w = WW'(1);
		end else if (row_width > ROW_WIDTH_W'(EFF_MAX)) begin
			w = WW'(EFF_MAX);
		end else begin
			w = WW'(row_width);
		end
	end

	assign last   = (WW'(wc_q) + WW'(1)) >= w;
	assign rd_end = (WW'(rc_q) + WW'(1)) >= w;
	assign rd_col = (WW'(rc_q) < w) ? CW'(w - WW'(1) - WW'(rc_q)) : '0;

	assign wr_addr = wb_q ? (AW'(MAX_ROW_WIDTH) + AW'(wc_q)) : AW'(wc_q);
	assign rd_addr = wb_q ? AW'(rd_col) : (AW'(MAX_ROW_WIDTH) + AW'(rd_col));

	assign from_mem = (drain || mirror_en) && pend_q;

	always_comb begin
		ctrl.emit     = accept && (drain ? pend_q : (!mirror_en || pend_q));
		ctrl.from_mem = accept && from_mem;
		ctrl.row_end  = from_mem ? rd_end : last;
		ctrl.wr_en    = accept && !drain && mirror_en;
		ctrl.sepia    = sepia_en;
	end

	always_comb begin
		wc_d   = wc_q;
		rc_d   = rc_q;
		wb_d   = wb_q;
		pend_d = pend_q;
		if (accept) begin
			if (from_mem) begin
				if (rd_end) begin
					pend_d = 1'b0;
					rc_d   = '0;
				end else begin
					rc_d = rc_q + CW'(1);
				end
			end
			if (!drain) begin
				if (last) begin
					wc_d = '0;
				end else begin
					wc_d = wc_q + CW'(1);
				end
				if (mirror_en && last) begin
					wb_d   = !wb_q;
					pend_d = 1'b1;
					rc_d   = '0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wc_q   <= '0;
			rc_q   <= '0;
			wb_q   <= 1'b0;
			pend_q <= 1'b0;
		end else begin
			wc_q   <= wc_d;
			rc_q   <= rc_d;
			wb_q   <= wb_d;
			pend_q <= pend_d;
		end
	end

	// a completed mirrored row is always waiting afterwards
	assert property (@(posedge clk) disable iff (!arst_n)
		accept && !drain && mirror_en && last |=> pend_q && (wb_q != $past(wb_q)))
	else $error("completed row not left pending");

	// writes and reads of one word go to opposite banks
	assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.wr_en && ctrl.from_mem |-> wr_addr != rd_addr)
	else $error("row store read and write collide");

	// write and read columns stay inside one bank
	assert property (@(posedge clk) disable iff (!arst_n)
		int'(wc_q) < MAX_ROW_WIDTH && int'(rc_q) < MAX_ROW_WIDTH)
	else $error("column beyond bank");

endmodule
`default_nettype wire

// ===== hw/rtl/spmr_sepia.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// spmr_sepia
// Three-stage sepia weighting: products, sums, reciprocal divide by 1000.
// ----------------------------------------------------------------------------
module spmr_sepia
	import spmr_pkg::*;
(
	input  logic   clk,
	input  pixel_t pix_s1,
	input  logic   sepia_s1,
	output pixel_t pix_s4
);

	logic [2:0][2:0][PROD_W-1:0] prod_s2;
	logic [2:0][SUM_W-1:0]       sum_s3;
	logic [2:0][QUOT_W-1:0]      quot_s4;
	logic [2:0][MUL_W-1:0]       recip_prod;

	pixel_t raw_s2, raw_s3, raw_s4;
	logic   sepia_s2, sepia_s3, sepia_s4;

	always_ff @(posedge clk) begin
		for (int o = 0; o < 3; o++) begin
			for (int i = 0; i < 3; i++) begin
				prod_s2[o][i] <= PROD_W'(sepia_coef(2'(o), 2'(i))) * PROD_W'(pix_s1[i]);
			end
		end
		raw_s2   <= pix_s1;
		sepia_s2 <= sepia_s1;
	end

	always_ff @(posedge clk) begin
		for (int o = 0; o < 3; o++) begin
			sum_s3[o] <= SUM_W'(prod_s2[o][0]) + SUM_W'(prod_s2[o][1]) + SUM_W'(prod_s2[o][2]);
		end
		raw_s3   <= raw_s2;
		sepia_s3 <= sepia_s2;
	end

	always_comb begin
		for (int o = 0; o < 3; o++) begin
			recip_prod[o] = MUL_W'(sum_s3[o]) * MUL_W'(SEPIA_RECIP);
		end
	end

	always_ff @(posedge clk) begin
		for (int o = 0; o < 3; o++) begin
			quot_s4[o] <= recip_prod[o][RECIP_SHIFT +: QUOT_W];
		end
		raw_s4   <= raw_s3;
		sepia_s4 <= sepia_s3;
	end

	// clamp at 255; pass the raw pixel when sepia is off
	always_comb begin
		for (int o = 0; o < 3; o++) begin
			if (!sepia_s4) begin
				pix_s4[o] = raw_s4[o];
			end else if (quot_s4[o] > QUOT_W'(255)) begin
				pix_s4[o] = '1;
			end else begin
				pix_s4[o] = quot_s4[o][PIX_W-1:0];
			end
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/spmr_row_store.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// spmr_row_store
// Two-bank row memory, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module spmr_row_store
	import spmr_pkg::*;
#(
	parameter int DEPTH = 2048,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  pixel_t        wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output pixel_t        rd_data
);

	pixel_t mem [0:DEPTH-1];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

// ===== hw/rtl/spmr_out_fifo.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// spmr_out_fifo
// Result queue that decouples the pipeline from output back-pressure.
// ----------------------------------------------------------------------------
module spmr_out_fifo
	import spmr_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  out_word_t              push_word,
	spmr_pix_out_if.source         pix_out
);

	out_word_t                mem_q [0:OUT_FIFO_DEPTH-1];
	logic [OUT_FIFO_AW-1:0]   wp_q, rp_q;
	logic [OUT_FIFO_CW-1:0]   count_q;
	logic                     pop;
	out_word_t                head;

	assign pop  = pix_out.valid && pix_out.ready;
	assign head = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wp_q] <= push_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= '0;
			rp_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wp_q <= wp_q + OUT_FIFO_AW'(1);
			end
			if (pop) begin
				rp_q <= rp_q + OUT_FIFO_AW'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + OUT_FIFO_CW'(1);
				2'b01:   count_q <= count_q - OUT_FIFO_CW'(1);
				default: count_q <= count_q;
			endcase
		end
	end

	assign pix_out.valid     = count_q != '0;
	assign pix_out.out_red   = head.pix[CH_RED];
	assign pix_out.out_green = head.pix[CH_GREEN];
	assign pix_out.out_blue  = head.pix[CH_BLUE];
	assign pix_out.row_end   = head.row_end;

	// credit flow control must never overfill the queue
	assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |-> count_q < OUT_FIFO_CW'(OUT_FIFO_DEPTH))
	else $error("result queue overflow");

endmodule
`default_nettype wire
